@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl files, included by the controller core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ipid_pkg.sv @@
package ipid_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int FRAC_W   = 8;

    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_ISTEP_LIM  = 3'd3,
        REG_OUT_LIM    = 3'd4
    } reg_idx_t;

endpackage

@@ rtl/incremental_pid_controller_core.sv @@
// a beat's error is registered, then its result, updating error history and last output
// throughput: one beat per cycle while the output is not stalled
// the feedback path through the stored output is a single add and clamp stage
// reset (aresetn low, synchronous): gains, limits, error history and last output cleared,
// both pipeline stages emptied
`include "assert_macros.svh"

module incremental_pid_controller_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ipid_pkg::ADDR_W-1:0]            paddr,
    input  logic [ipid_pkg::DATA_W-1:0]            pwdata,
    output logic [ipid_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [ipid_pkg::SAMPLE_W-1:0]   s_reference,
    input  logic signed [ipid_pkg::SAMPLE_W-1:0]   s_feedback,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ipid_pkg::SAMPLE_W-1:0]   m_drive
);

    // configuration registers
    logic signed [15:0] gain_p_reg;
    logic signed [15:0] gain_i_reg;
    logic signed [15:0] gain_d_reg;
    logic [14:0]        istep_lim_reg;
    logic [14:0]        out_lim_reg;

    ipid_pkg::reg_idx_t reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = ipid_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            istep_lim_reg <= '0;
            out_lim_reg   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                ipid_pkg::REG_GAIN_P:    gain_p_reg    <= pwdata[15:0];
                ipid_pkg::REG_GAIN_I:    gain_i_reg    <= pwdata[15:0];
                ipid_pkg::REG_GAIN_D:    gain_d_reg    <= pwdata[15:0];
                ipid_pkg::REG_ISTEP_LIM: istep_lim_reg <= pwdata[14:0];
                ipid_pkg::REG_OUT_LIM:   out_lim_reg   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ipid_pkg::REG_GAIN_P:    prdata = {16'd0, gain_p_reg};
            ipid_pkg::REG_GAIN_I:    prdata = {16'd0, gain_i_reg};
            ipid_pkg::REG_GAIN_D:    prdata = {16'd0, gain_d_reg};
            ipid_pkg::REG_ISTEP_LIM: prdata = {17'd0, istep_lim_reg};
            ipid_pkg::REG_OUT_LIM:   prdata = {17'd0, out_lim_reg};
            default:                 prdata = '0;
        endcase
    end

    // input stage: error formed on entry
    logic               in_valid_reg;
    logic signed [16:0] e0_reg;
    logic signed [16:0] e0_next;
    logic               advance;

    assign e0_next = {s_reference[15], s_reference} - {s_feedback[15], s_feedback};
    assign advance = in_valid_reg & (~m_valid | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            e0_reg <= e0_next;
        end
    end

    // controller state
    logic signed [16:0] e1_reg;
    logic signed [16:0] e2_reg;
    logic signed [15:0] out_prev_reg;
    logic               out_valid_reg;
    logic signed [15:0] drive_reg;

    // increments
    logic signed [17:0] diff_p;
    logic signed [18:0] diff_d;
    logic signed [33:0] prod_p;
    logic signed [32:0] prod_i;
    logic signed [34:0] prod_d;
    logic signed [25:0] inc_p;
    logic signed [24:0] inc_i_raw;
    logic signed [26:0] inc_d;
    logic signed [24:0] ilim_pos;
    logic signed [24:0] ilim_neg;
    logic signed [15:0] inc_i;
    logic signed [28:0] sum;
    logic signed [28:0] olim_pos;
    logic signed [28:0] olim_neg;
    logic signed [15:0] drive_next;

    assign diff_p = {e0_reg[16], e0_reg} - {e1_reg[16], e1_reg};
    assign diff_d = {{2{e0_reg[16]}}, e0_reg} - {e1_reg[16], e1_reg, 1'b0}
                  + {{2{e2_reg[16]}}, e2_reg};

    assign prod_p = gain_p_reg * diff_p;
    assign prod_i = gain_i_reg * e0_reg;
    assign prod_d = gain_d_reg * diff_d;

    // arithmetic shift by the fraction width, floor rounding
    assign inc_p     = prod_p[33:ipid_pkg::FRAC_W];
    assign inc_i_raw = prod_i[32:ipid_pkg::FRAC_W];
    assign inc_d     = prod_d[34:ipid_pkg::FRAC_W];

    assign ilim_pos = {10'd0, istep_lim_reg};
    assign ilim_neg = -ilim_pos;

    always_comb begin
        if (inc_i_raw > ilim_pos) begin
            inc_i = ilim_pos[15:0];
        end else if (inc_i_raw < ilim_neg) begin
            inc_i = ilim_neg[15:0];
        end else begin
            inc_i = inc_i_raw[15:0];
        end
    end

    assign sum = {{13{out_prev_reg[15]}}, out_prev_reg}
               + {{3{inc_p[25]}}, inc_p}
               + {{13{inc_i[15]}}, inc_i}
               + {{2{inc_d[26]}}, inc_d};

    assign olim_pos = {14'd0, out_lim_reg};
    assign olim_neg = -olim_pos;

    always_comb begin
        if (sum > olim_pos) begin
            drive_next = olim_pos[15:0];
        end else if (sum < olim_neg) begin
            drive_next = olim_neg[15:0];
        end else begin
            drive_next = sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg        <= '0;
            e2_reg        <= '0;
            out_prev_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                e1_reg       <= e0_reg;
                e2_reg       <= e1_reg;
                out_prev_reg <= drive_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg <= drive_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_drive = drive_reg;

    // the pending result is always the stored last output
    `ASSERT_IMPL(a_drive_is_state, aclk, aresetn, m_valid, m_drive == out_prev_reg)
    // both stages full and stalled: no new beat taken
    `ASSERT_IMPL(a_full_blocks, aclk, aresetn, in_valid_reg && m_valid && !m_ready, !s_ready)
    // a step always produces a result beat
    `ASSERT_NEXT(a_step_emits, aclk, aresetn, advance, m_valid)
    // error history shifts by one per step
    `ASSERT_NEXT(a_hist_shift, aclk, aresetn, advance,
        e1_reg == $past(e0_reg) && e2_reg == $past(e1_reg))

endmodule

@@ sim/incremental_pid_controller_core_tb.sv @@
`timescale 1ns / 100ps

module incremental_pid_controller_core_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS = 125;
    // indexes with no register behind them
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef logic [ipid_pkg::SAMPLE_W-1:0] sample_word_t;
    typedef logic [ipid_pkg::GAIN_W-1:0]   gain_word_t;
    typedef logic [ipid_pkg::LIMIT_W-1:0]  limit_word_t;

    typedef struct packed {
        logic [ipid_pkg::SAMPLE_W-1:0] reference;
        logic [ipid_pkg::SAMPLE_W-1:0] feedback;
    } sample_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [ipid_pkg::ADDR_W-1:0]          paddr;
    logic [ipid_pkg::DATA_W-1:0]          pwdata;
    logic [ipid_pkg::DATA_W-1:0]          prdata;
    logic                                 pready;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [ipid_pkg::SAMPLE_W-1:0] s_reference;
    logic signed [ipid_pkg::SAMPLE_W-1:0] s_feedback;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [ipid_pkg::SAMPLE_W-1:0] m_drive;

    // controller settings and history as the testbench tracks them
    logic signed [ipid_pkg::GAIN_W-1:0]   gain_p;
    logic signed [ipid_pkg::GAIN_W-1:0]   gain_i;
    logic signed [ipid_pkg::GAIN_W-1:0]   gain_d;
    logic [ipid_pkg::LIMIT_W-1:0]         istep_lim;
    logic [ipid_pkg::LIMIT_W-1:0]         out_lim;
    logic signed [ipid_pkg::ERR_W-1:0]    err_prev;
    logic signed [ipid_pkg::ERR_W-1:0]    err_prev2;
    logic signed [ipid_pkg::SAMPLE_W-1:0] out_prev;

    sample_t                              sample_q[$];
    logic [ipid_pkg::SAMPLE_W-1:0]        drive_q[$];
    sample_t                              next_sample;
    logic [ipid_pkg::SAMPLE_W-1:0]        expected_drive;
    logic                                 s_taken;
    logic                                 quiet;
    int                                   idle_cycles;
    int                                   errors;

    incremental_pid_controller_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_reference (s_reference),
        .s_feedback  (s_feedback),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive     (m_drive)
    );

    always #6 aclk = ~aclk;

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic [ipid_pkg::SAMPLE_W-1:0] predict_drive(
        input logic signed [ipid_pkg::SAMPLE_W-1:0] r,
        input logic signed [ipid_pkg::SAMPLE_W-1:0] f
    );
        longint e0;
        longint p_inc;
        longint i_inc;
        longint d_inc;
        longint y;
        e0 = longint'(r) - longint'(f);
        p_inc = (longint'(gain_p) * (e0 - longint'(err_prev))) >>> ipid_pkg::FRAC_W;
        i_inc = clamp_sym((longint'(gain_i) * e0) >>> ipid_pkg::FRAC_W,
                          longint'(istep_lim));
        d_inc = (longint'(gain_d) * (e0 - 2 * longint'(err_prev) + longint'(err_prev2)))
                >>> ipid_pkg::FRAC_W;
        y = clamp_sym(longint'(out_prev) + p_inc + i_inc + d_inc, longint'(out_lim));
        err_prev2 = err_prev;
        err_prev  = e0[ipid_pkg::ERR_W-1:0];
        out_prev  = y[ipid_pkg::SAMPLE_W-1:0];
        return y[ipid_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic logic [ipid_pkg::SAMPLE_W-1:0] small_value(input int span);
        return sample_word_t'(int'($urandom_range(2 * span - 1)) - span);
    endfunction

    // upper bits are junk on purpose, the block must drop them
    function automatic logic [ipid_pkg::DATA_W-1:0] pick_gain();
        logic [ipid_pkg::GAIN_W-1:0] g;
        case ($urandom_range(3))
            0: g = gain_word_t'($urandom());
            1: g = small_value(512);
            2: g = small_value(48);
            default: begin
                case ($urandom_range(3))
                    0: g = 16'h8000;
                    1: g = 16'h7FFF;
                    2: g = 16'h0000;
                    default: g = 16'h0100;
                endcase
            end
        endcase
        return {16'($urandom()), g};
    endfunction

    function automatic logic [ipid_pkg::DATA_W-1:0] pick_limit();
        logic [ipid_pkg::LIMIT_W-1:0] lim;
        case ($urandom_range(3))
            0: lim = '0;
            1: lim = '1;
            default: lim = limit_word_t'($urandom());
        endcase
        return {17'($urandom()), lim};
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [ipid_pkg::DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            ipid_pkg::REG_GAIN_P:    gain_p    = data[ipid_pkg::GAIN_W-1:0];
            ipid_pkg::REG_GAIN_I:    gain_i    = data[ipid_pkg::GAIN_W-1:0];
            ipid_pkg::REG_GAIN_D:    gain_d    = data[ipid_pkg::GAIN_W-1:0];
            ipid_pkg::REG_ISTEP_LIM: istep_lim = data[ipid_pkg::LIMIT_W-1:0];
            ipid_pkg::REG_OUT_LIM:   out_lim   = data[ipid_pkg::LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_sample(input logic [ipid_pkg::SAMPLE_W-1:0] r,
                               input logic [ipid_pkg::SAMPLE_W-1:0] f);
        sample_q.push_back('{reference: r, feedback: f});
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || s_valid || drive_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // driver: next beat offered at the falling edge once the current one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_taken) begin
                if (sample_q.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
                    next_sample = sample_q.pop_front();
                    s_valid     <= 1'b1;
                    s_reference <= next_sample.reference;
                    s_feedback  <= next_sample.feedback;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // monitor and stall watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            s_taken <= s_valid && s_ready;
            // check before predicting, a result never belongs to a beat taken this edge
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result beat: expected none, got drive %0d",
                             $time, m_drive);
                end else begin
                    expected_drive = drive_q.pop_front();
                    if (m_drive !== expected_drive) begin
                        errors++;
                        $display("%0t drive mismatch: expected %0d, got %0d",
                                 $time, $signed(expected_drive), m_drive);
                    end
                end
            end
            if (s_valid && s_ready)
                drive_q.push_back(predict_drive(s_reference, s_feedback));
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (psel && penable && pwrite && pready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [ipid_pkg::SAMPLE_W-1:0] r;
        logic [ipid_pkg::SAMPLE_W-1:0] f;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_reference = '0;
        s_feedback  = '0;
        m_ready     = 1'b0;
        quiet       = 1'b0;
        errors      = 0;
        gain_p      = '0;
        gain_i      = '0;
        gain_d      = '0;
        istep_lim   = '0;
        out_lim     = '0;
        err_prev    = '0;
        err_prev2   = '0;
        out_prev    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: both limits zero, drive pinned at zero
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h8000, 16'h7FFF);
        wait_drained();

        // moderate gains; writes to spare indexes must change nothing
        write_reg(ipid_pkg::REG_GAIN_P, 32'h0000_0100);
        write_reg(ipid_pkg::REG_GAIN_I, 32'h0000_0080);
        write_reg(ipid_pkg::REG_GAIN_D, 32'h0000_0040);
        write_reg(ipid_pkg::REG_ISTEP_LIM, 32'd1000);
        write_reg(ipid_pkg::REG_OUT_LIM, 32'd20000);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h8000, 16'h7FFF);
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'd100, 16'd50);
        push_sample(16'hFFFF, 16'h0000);
        push_sample(16'h0000, 16'hFFFF);
        push_sample(16'h7FFF, 16'h7FFF);
        wait_drained();

        // extreme gains and full-scale limits, junk in the upper bits
        write_reg(ipid_pkg::REG_GAIN_P, 32'hFFFF_8000);
        write_reg(ipid_pkg::REG_GAIN_I, 32'hA5A5_7FFF);
        write_reg(ipid_pkg::REG_GAIN_D, 32'h0000_8000);
        write_reg(ipid_pkg::REG_ISTEP_LIM, 32'h0000_7FFF);
        write_reg(ipid_pkg::REG_OUT_LIM, 32'hFFFF_FFFF);
        push_sample(16'h8000, 16'h7FFF);
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'h0001, 16'h0000);
        push_sample(16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h0000);
        wait_drained();

        // zero clamp on the integral step
        write_reg(ipid_pkg::REG_GAIN_P, 32'h0000_7FFF);
        write_reg(ipid_pkg::REG_GAIN_I, 32'h0000_8000);
        write_reg(ipid_pkg::REG_GAIN_D, 32'h0000_7FFF);
        write_reg(ipid_pkg::REG_ISTEP_LIM, 32'hFFFF_8000);
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h8000, 16'h7FFF);
        push_sample(16'h1234, 16'h0000);
        push_sample(16'h0000, 16'h4321);
        wait_drained();

        // zero clamp on the output
        write_reg(ipid_pkg::REG_OUT_LIM, 32'h0000_0000);
        push_sample(16'h7FFF, 16'h8000);
        push_sample(16'h8000, 16'h0000);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet = (ph == 3);
            write_reg(ipid_pkg::REG_GAIN_P, pick_gain());
            write_reg(ipid_pkg::REG_GAIN_I, pick_gain());
            write_reg(ipid_pkg::REG_GAIN_D, pick_gain());
            write_reg(ipid_pkg::REG_ISTEP_LIM, pick_limit());
            write_reg(ipid_pkg::REG_OUT_LIM, pick_limit());
            for (int i = 0; i < PHASE_BEATS; i++) begin
                case ($urandom_range(3))
                    0: begin
                        r = sample_word_t'($urandom());
                        f = sample_word_t'($urandom());
                    end
                    1: begin
                        // feedback tracking the reference closely
                        r = sample_word_t'($urandom());
                        f = r + small_value(64);
                    end
                    2: begin
                        r = small_value(2048);
                        f = small_value(2048);
                    end
                    default: begin
                        case ($urandom_range(3))
                            0: r = 16'h7FFF;
                            1: r = 16'h8000;
                            2: r = 16'h0000;
                            default: r = 16'hFFFF;
                        endcase
                        case ($urandom_range(3))
                            0: f = 16'h7FFF;
                            1: f = 16'h8000;
                            2: f = 16'h0000;
                            default: f = 16'hFFFF;
                        endcase
                    end
                endcase
                push_sample(r, f);
            end
            wait_drained();
        end
        quiet = 1'b0;

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
